/* rtl/blnp_pkg.sv */
// Shared constants, codes and types of the beat line note parser.
`default_nettype none

package blnp_pkg;

  localparam int CHAR_W = 8;
  localparam int NOTE_W = 11;
  localparam int KIND_W = 2;
  localparam int ERR_W = 2;
  localparam int CNT_W = 16;
  localparam int MODE_W = 2;
  localparam int DIGIT_W = 4;
  localparam int RES_CNT_W = 2;

  localparam int MAX_NOTES_DEF = 128;

  // Parser modes.
  localparam logic [MODE_W-1:0] MODE_SEEK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NUM = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SKIP = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_NOTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEAT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_EXPECTED = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INDEX = 2'd1;
  localparam logic [ERR_W-1:0] ERR_INVALID = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY = 2'd3;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BAR = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

  localparam logic [NOTE_W-1:0] NOTE_LIMIT = 11'd2000;
  localparam logic [NOTE_W-1:0] DIGIT_SAT = 11'd2047;
  localparam logic [CNT_W-1:0] LINE_RESET = 16'd2;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] item_kind;
    logic [NOTE_W-1:0] note_value;
    logic [ERR_W-1:0]  error_code;
    logic [CNT_W-1:0]  line_number;
    logic [CNT_W-1:0]  char_position;
    logic              last;
  } res_item_t;

  // Parser context; the two lowest decimal digits of the number give its
  // remainder by one hundred.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [NOTE_W-1:0]  digit_value;
    logic [DIGIT_W-1:0] low_tens;
    logic [DIGIT_W-1:0] low_ones;
    logic [CNT_W-1:0]   line_count;
    logic [CNT_W-1:0]   char_count;
  } ctx_t;

endpackage

`default_nettype wire

/* rtl/blnp_in_if.sv */
// Input byte channel of the beat line note parser.
`default_nettype none

interface blnp_in_if;
  import blnp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

/* rtl/blnp_res_if.sv */
// Result channel of the beat line note parser.
`default_nettype none

interface blnp_res_if;
  import blnp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] item_kind;
  logic [NOTE_W-1:0] note_value;
  logic [ERR_W-1:0]  error_code;
  logic [CNT_W-1:0]  line_number;
  logic [CNT_W-1:0]  char_position;
  logic              last;

  modport source (
    output valid, output item_kind, output note_value, output error_code,
    output line_number, output char_position, output last, input ready
  );
  modport sink (
    input valid, input item_kind, input note_value, input error_code,
    input line_number, input char_position, input last, output ready
  );
endinterface

`default_nettype wire

/* rtl/beat_line_note_parser_core.sv */
// Top level of the beat line note parser: input register, parser state and results.
//
//   channel | modport | payload                                     | per transfer
//   --------+---------+---------------------------------------------+---------------
//   in_i    | sink    | char_code, end_of_input                     | one byte or EOF
//   out_o   | source  | item_kind, note_value, error_code,          | one result
//           |         | line_number, char_position, last            |
//
// A byte is taken into the input register and parsed once the result register is free;
// its results are held in the result register and offered on out_o from there. Bytes giving no
// result or one result pass at one per cycle while out_o accepts; a byte giving two results
// (an error or a note followed by an end-of-beat mark) holds the result register until both have left.
// The result register is the rate limit: it emits at most one result per cycle.
// Reset is asynchronous and active low; it returns the parser to seeking the index
// bracket on line two and empties both registers.
// When out_o stalls, one more byte still enters the input register, and in_i stalls
// only once that byte cannot be parsed.
`default_nettype none

module beat_line_note_parser_core #(
  parameter int MaxNotes = blnp_pkg::MAX_NOTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  blnp_in_if.sink          in_i,
  blnp_res_if.source       out_o
);
  import blnp_pkg::*;

  localparam int NotesW = $clog2(MaxNotes + 1);

  // Input register: holds one accepted byte until it can be parsed.
  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      in_take;

  // Parser state.
  ctx_t               ctx_q, ctx_d;
  logic [NotesW-1:0]  notes_q, notes_d;

  // Results of the byte being parsed.
  res_item_t              res0;
  res_item_t              res1;
  logic [RES_CNT_W-1:0]   res_cnt;

  logic       can_load;
  logic       fire;
  logic       pop;
  logic       res_valid;
  res_item_t  head;

  // The held byte is parsed once the result register can take all its results.
  assign fire = in_valid_q && can_load;
  assign pop = res_valid && out_o.ready;

  // A new byte enters whenever the input register is empty or being emptied.
  assign in_i.ready = !in_valid_q || fire;
  assign in_take = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.char_code <= in_i.char_code;
      in_item_q.end_of_input <= in_i.end_of_input;
    end
  end

  blnp_step #(
    .MaxNotes (MaxNotes),
    .NotesW   (NotesW)
  ) u_step (
    .item_i    (in_item_q),
    .ctx_i     (ctx_q),
    .notes_i   (notes_q),
    .ctx_o     (ctx_d),
    .notes_o   (notes_d),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  // The parser state moves only when a byte is actually parsed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.mode <= MODE_SEEK;
      ctx_q.digit_value <= '0;
      ctx_q.low_tens <= '0;
      ctx_q.low_ones <= '0;
      ctx_q.line_count <= LINE_RESET;
      ctx_q.char_count <= '0;
      notes_q <= '0;
    end else if (fire) begin
      ctx_q <= ctx_d;
      notes_q <= notes_d;
    end
  end

  blnp_res_buf u_res_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .res0_i     (res0),
    .res1_i     (res1),
    .res_cnt_i  (res_cnt),
    .pop_i      (pop),
    .can_load_o (can_load),
    .valid_o    (res_valid),
    .head_o     (head)
  );

  assign out_o.valid = res_valid;
  assign out_o.item_kind = head.item_kind;
  assign out_o.note_value = head.note_value;
  assign out_o.error_code = head.error_code;
  assign out_o.line_number = head.line_number;
  assign out_o.char_position = head.char_position;
  assign out_o.last = head.last;

endmodule

`default_nettype wire

/* rtl/blnp_step.sv */
// Next-state and result logic for one input byte of the parser.
`default_nettype none

module blnp_step #(
  parameter int MaxNotes = blnp_pkg::MAX_NOTES_DEF,
  parameter int NotesW = $clog2(MaxNotes + 1)
) (
  input  blnp_pkg::in_item_t              item_i,
  input  blnp_pkg::ctx_t                  ctx_i,
  input  logic [NotesW-1:0]               notes_i,
  output blnp_pkg::ctx_t                  ctx_o,
  output logic [NotesW-1:0]               notes_o,
  output blnp_pkg::res_item_t             res0_o,
  output blnp_pkg::res_item_t             res1_o,
  output logic [blnp_pkg::RES_CNT_W-1:0]  res_cnt_o
);
  import blnp_pkg::*;

  logic              eof;
  logic [CHAR_W-1:0] c;
  logic              is_space;
  logic              nl;
  logic              bar;
  logic              digit;
  logic [DIGIT_W-1:0] dig;
  logic [NOTE_W+3:0] dv_wide;
  logic [NOTE_W-1:0] dv_sat;
  logic              note_ok;
  logic              p_valid;
  logic [KIND_W-1:0] p_kind;
  logic [ERR_W-1:0]  p_code;
  logic [NOTE_W-1:0] p_note;
  logic              eol;
  res_item_t         prim;
  res_item_t         beat;

  assign eof = item_i.end_of_input;
  assign c = item_i.char_code;
  assign is_space = !eof && (c == CH_SPACE);
  assign nl = !eof && (c == CH_NEWLINE);
  assign bar = !eof && (c == CH_BAR);
  assign digit = !eof && (c >= CH_ZERO) && (c <= CH_NINE);
  assign dig = c[DIGIT_W-1:0];

  // Ten times the value plus the new digit, saturating.
  assign dv_wide = {ctx_i.digit_value, 3'b000} + {2'b00, ctx_i.digit_value, 1'b0}
                 + {{(NOTE_W){1'b0}}, dig};
  assign dv_sat = (dv_wide > {4'b0000, DIGIT_SAT}) ? DIGIT_SAT : dv_wide[NOTE_W-1:0];

  // Below 2000 and the last two digits under twelve.
  assign note_ok = (ctx_i.digit_value < NOTE_LIMIT)
                && ((ctx_i.low_tens == 4'd0)
                    || ((ctx_i.low_tens == 4'd1) && (ctx_i.low_ones < 4'd2)));

  always_comb begin
    ctx_o = ctx_i;
    notes_o = notes_i;
    p_valid = 1'b0;
    p_kind = KIND_NOTE;
    p_code = ERR_EXPECTED;
    p_note = '0;
    eol = 1'b0;

    if (!is_space) begin
      case (ctx_i.mode)
        MODE_SEEK: begin
          if (eof) begin
            eol = 1'b1;
          end else if (c == CH_CLOSE) begin
            ctx_o.mode = MODE_FIND;
          end else if (nl || bar) begin
            p_valid = 1'b1;
            p_kind = KIND_ERR;
            p_code = ERR_INDEX;
            ctx_o.mode = MODE_SKIP;
            eol = nl;
          end
        end
        MODE_FIND: begin
          if (digit) begin
            ctx_o.digit_value = {{(NOTE_W-DIGIT_W){1'b0}}, dig};
            ctx_o.low_tens = '0;
            ctx_o.low_ones = dig;
            ctx_o.mode = MODE_NUM;
          end else if (nl || eof) begin
            eol = 1'b1;
          end else if (!bar) begin
            p_valid = 1'b1;
            p_kind = KIND_ERR;
            p_code = ERR_EXPECTED;
            ctx_o.mode = MODE_SKIP;
          end
        end
        MODE_NUM: begin
          if (digit) begin
            ctx_o.digit_value = dv_sat;
            ctx_o.low_tens = ctx_i.low_ones;
            ctx_o.low_ones = dig;
          end else if (nl || eof || bar) begin
            p_valid = 1'b1;
            if (!note_ok) begin
              p_kind = KIND_ERR;
              p_code = ERR_INVALID;
              ctx_o.mode = MODE_SKIP;
            end else if (notes_i >= NotesW'(MaxNotes)) begin
              p_kind = KIND_ERR;
              p_code = ERR_TOO_MANY;
              ctx_o.mode = MODE_SKIP;
            end else begin
              p_kind = KIND_NOTE;
              p_note = ctx_i.digit_value;
              notes_o = notes_i + 1'b1;
              ctx_o.mode = MODE_FIND;
            end
            ctx_o.digit_value = '0;
            eol = nl || eof;
          end else begin
            p_valid = 1'b1;
            p_kind = KIND_ERR;
            p_code = ERR_EXPECTED;
            ctx_o.mode = MODE_SKIP;
          end
        end
        default: begin
          eol = nl || eof;
        end
      endcase

      if (ctx_i.char_count != '1) begin
        ctx_o.char_count = ctx_i.char_count + 1'b1;
      end

      if (eol) begin
        if (ctx_i.line_count != '1) begin
          ctx_o.line_count = ctx_i.line_count + 1'b1;
        end
        ctx_o.char_count = '0;
        ctx_o.digit_value = '0;
        ctx_o.low_tens = '0;
        ctx_o.low_ones = '0;
        notes_o = '0;
        ctx_o.mode = MODE_SEEK;
      end
    end
  end

  always_comb begin
    prim.item_kind = p_kind;
    prim.note_value = p_note;
    prim.error_code = (p_kind == KIND_ERR) ? p_code : ERR_EXPECTED;
    prim.line_number = ctx_i.line_count;
    prim.char_position = ctx_i.char_count;
    prim.last = !eol;

    beat.item_kind = KIND_BEAT;
    beat.note_value = '0;
    beat.error_code = ERR_EXPECTED;
    beat.line_number = ctx_i.line_count;
    beat.char_position = ctx_i.char_count;
    beat.last = 1'b1;

    res0_o = p_valid ? prim : beat;
    res1_o = beat;
    res_cnt_o = {1'b0, p_valid} + {1'b0, eol};
  end

endmodule

`default_nettype wire

/* rtl/blnp_res_buf.sv */
// Two-entry result register that hands results out one transfer at a time.
`default_nettype none

module blnp_res_buf (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  blnp_pkg::res_item_t             res0_i,
  input  blnp_pkg::res_item_t             res1_i,
  input  logic [blnp_pkg::RES_CNT_W-1:0]  res_cnt_i,
  input  logic                            pop_i,
  output logic                            can_load_o,
  output logic                            valid_o,
  output blnp_pkg::res_item_t             head_o
);
  import blnp_pkg::*;

  res_item_t              slot0_q, slot0_d;
  res_item_t              slot1_q, slot1_d;
  logic [RES_CNT_W-1:0]   cnt_q, cnt_d;

  // A new pair is taken only once the last held result leaves.
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_i);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o = slot0_q;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d = cnt_q;
    if (load_i) begin
      slot0_d = res0_i;
      slot1_d = res1_i;
      cnt_d = res_cnt_i;
    end else if (pop_i) begin
      slot0_d = slot1_q;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

/* rtl/blnp_checker.sv */
// Port-level checks of the beat line note parser and their binding to the top level.
`default_nettype none

module blnp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [blnp_pkg::KIND_W-1:0]   item_kind_i,
  input logic [blnp_pkg::NOTE_W-1:0]   note_value_i,
  input logic [blnp_pkg::ERR_W-1:0]    error_code_i,
  input logic [blnp_pkg::CNT_W-1:0]    line_number_i,
  input logic [blnp_pkg::CNT_W-1:0]    char_position_i,
  input logic                          last_i
);
  import blnp_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid_i && out_ready_i;

  // A stalled result keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(item_kind_i) && $stable(note_value_i)
      && $stable(error_code_i) && $stable(line_number_i) && $stable(char_position_i)
      && $stable(last_i))
    else $error("result payload changed while stalled");

  // A result that is not the last of its byte is followed at once by the closing
  // end-of-beat mark of the same line, because both are held together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_i |=> out_valid_i && (item_kind_i == KIND_BEAT) && last_i
      && (line_number_i == $past(line_number_i))
      && (char_position_i == $past(char_position_i)))
    else $error("first of two results not followed by its end-of-beat mark");

  // An end-of-beat mark always closes the results of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (item_kind_i == KIND_BEAT) |-> last_i && (note_value_i == '0))
    else $error("end-of-beat mark not last or carries a note");

  // Leaving reset, no result is on offer.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result offered straight out of reset");

endmodule

bind beat_line_note_parser_core blnp_checker u_blnp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .item_kind_i     (out_o.item_kind),
  .note_value_i    (out_o.note_value),
  .error_code_i    (out_o.error_code),
  .line_number_i   (out_o.line_number),
  .char_position_i (out_o.char_position),
  .last_i          (out_o.last)
);

`default_nettype wire

/* verif/beat_line_note_parser_core_tb.sv */
// Self-checking testbench for the beat line note parser core.
`default_nettype none

module beat_line_note_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blnp_pkg::*;

  // The per-beat note capacity of the block as built by default.
  localparam int NotesPerBeat = MAX_NOTES_DEF;
  // Number of decimal keys per octave and the octave step of a note value.
  localparam int KeysPerOctave = 12;
  localparam int OctaveStep = 100;
  // Stimulus volume and run limits.
  localparam int RandomBytes = 1950;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 20;
  localparam int CycleLimit = 1000000;

  // Predicts every result of the parser and checks the results in order.
  class note_scoreboard;
    int unsigned      beat_cap;
    logic [MODE_W-1:0] state_mode;
    logic [NOTE_W-1:0] acc_value;
    logic [7:0]        line_notes;
    logic [CNT_W-1:0]  line_no;
    logic [CNT_W-1:0]  col_no;
    res_item_t         pending[$];
    int unsigned       mismatches;

    function new(int unsigned cap);
      beat_cap = cap;
      state_mode = MODE_SEEK;
      acc_value = '0;
      line_notes = '0;
      line_no = LINE_RESET;
      col_no = '0;
      mismatches = 0;
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [NOTE_W-1:0] note,
                       logic [ERR_W-1:0] code, logic [CNT_W-1:0] line_at,
                       logic [CNT_W-1:0] pos_at);
      res_item_t r;
      r.item_kind = kind;
      r.note_value = note;
      r.error_code = code;
      r.line_number = line_at;
      r.char_position = pos_at;
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    // Works out the results of one accepted byte or end-of-file mark.
    function void note_input(logic [CHAR_W-1:0] c, logic eof);
      bit               nl, bar, dig, eol;
      int               v, first;
      logic [CNT_W-1:0] line_at, pos_at;
      if (!eof && c == CH_SPACE) return;
      first = pending.size();
      line_at = line_no;
      pos_at = col_no;
      nl = !eof && c == CH_NEWLINE;
      bar = !eof && c == CH_BAR;
      dig = !eof && c >= CH_ZERO && c <= CH_NINE;
      eol = 1'b0;
      case (state_mode)
        MODE_SEEK: begin
          if (eof) begin
            eol = 1'b1;
          end else if (c == CH_CLOSE) begin
            state_mode = MODE_FIND;
          end else if (nl || bar) begin
            push(KIND_ERR, '0, ERR_INDEX, line_at, pos_at);
            state_mode = MODE_SKIP;
            eol = nl;
          end
        end
        MODE_FIND: begin
          if (dig) begin
            acc_value = NOTE_W'(int'(c) - int'(CH_ZERO));
            state_mode = MODE_NUM;
          end else if (nl || eof) begin
            eol = 1'b1;
          end else if (!bar) begin
            push(KIND_ERR, '0, ERR_EXPECTED, line_at, pos_at);
            state_mode = MODE_SKIP;
          end
        end
        MODE_NUM: begin
          if (dig) begin
            v = int'(acc_value) * 10 + int'(c) - int'(CH_ZERO);
            acc_value = (v > int'(DIGIT_SAT)) ? DIGIT_SAT : NOTE_W'(v);
          end else if (nl || eof || bar) begin
            v = int'(acc_value);
            if (v >= int'(NOTE_LIMIT) || v % OctaveStep >= KeysPerOctave) begin
              push(KIND_ERR, '0, ERR_INVALID, line_at, pos_at);
              state_mode = MODE_SKIP;
            end else if (line_notes >= beat_cap) begin
              push(KIND_ERR, '0, ERR_TOO_MANY, line_at, pos_at);
              state_mode = MODE_SKIP;
            end else begin
              push(KIND_NOTE, acc_value, ERR_EXPECTED, line_at, pos_at);
              line_notes = line_notes + 8'd1;
              state_mode = MODE_FIND;
            end
            acc_value = '0;
            eol = nl || eof;
          end else begin
            push(KIND_ERR, '0, ERR_EXPECTED, line_at, pos_at);
            state_mode = MODE_SKIP;
          end
        end
        default: begin
          eol = nl || eof;
        end
      endcase
      if (col_no != '1) col_no = col_no + 1'b1;
      if (eol) begin
        push(KIND_BEAT, '0, ERR_EXPECTED, line_at, pos_at);
        if (line_no != '1) line_no = line_no + 1'b1;
        col_no = '0;
        acc_value = '0;
        line_notes = '0;
        state_mode = MODE_SEEK;
      end
      if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(res_item_t got);
      res_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      field_check("item_kind", want.item_kind, got.item_kind);
      field_check("note_value", want.note_value, got.note_value);
      field_check("error_code", want.error_code, got.error_code);
      field_check("line_number", want.line_number, got.line_number);
      field_check("char_position", want.char_position, got.char_position);
      field_check("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  blnp_in_if  in_if ();
  blnp_res_if res_if ();

  beat_line_note_parser_core #(
    .MaxNotes(NotesPerBeat)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (res_if)
  );

  note_scoreboard sb;

  // Sender and receiver controls shared between the processes below.
  int unsigned sent_bytes;
  int unsigned burst_left;
  int unsigned cycles;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a correct run finishes far inside this many cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: run stopped after %0d cycles", $time, cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge. Input transfers are
  // recorded before result transfers, although a byte cannot produce a
  // result at the edge on which it is taken.
  always @(posedge clk) begin
    res_item_t got;
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_input(in_if.char_code, in_if.end_of_input);
    end
    if (rst_n && res_if.valid && res_if.ready) begin
      got.item_kind = res_if.item_kind;
      got.note_value = res_if.note_value;
      got.error_code = res_if.error_code;
      got.line_number = res_if.line_number;
      got.char_position = res_if.char_position;
      got.last = res_if.last;
      sb.check_result(got);
    end
  end

  // Receiver. It switches between stretches of steady acceptance, random
  // stalls, sparse acceptance and a fixed rhythm. On request it holds off
  // for a long stretch so that the parser fills up and stalls its input.
  initial begin
    int unsigned stretch_left;
    int unsigned rhythm;
    int unsigned pattern;
    res_if.ready = 1'b0;
    stretch_left = 0;
    rhythm = 0;
    pattern = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          pattern = $urandom_range(0, 3);
          stretch_left = $urandom_range(10, 80);
        end
        stretch_left--;
        rhythm++;
        case (pattern)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (rhythm % 3 != 0);
        endcase
      end
    end
  end

  // Offers one byte (or an end-of-file mark) and waits for its transfer.
  // The sender works in bursts; between bursts it idles for a few cycles,
  // or not at all, so that gaps land on every phase of the parser.
  task automatic send_item(input logic [CHAR_W-1:0] c, input logic eof);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.char_code <= c;
    in_if.end_of_input <= eof;
    do @(posedge clk); while (!in_if.ready);
    sent_bytes++;
  endtask

  // A byte that is neither a space, a digit nor one of the markers.
  function automatic logic [CHAR_W-1:0] pick_filler();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255));
    while (c == CH_CLOSE || c == CH_NEWLINE || c == CH_BAR || c == CH_SPACE ||
           (c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  // A note the parser must accept: octave times one hundred plus a key.
  function automatic int pick_note();
    return $urandom_range(0, 19) * OctaveStep + $urandom_range(0, KeysPerOctave - 1);
  endfunction

  // Sends a byte, now and then preceded by a space that must be ignored.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    if ($urandom_range(0, 11) == 0) send_item(CH_SPACE, 1'b0);
    send_item(c, 1'b0);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Decimal digits of a number, sometimes with a leading zero.
  task automatic send_number(input int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) send_char(CH_ZERO);
    foreach (s[i]) send_char(s[i]);
  endtask

  // Something in a note slot that the parser usually rejects.
  task automatic send_bad_token();
    case ($urandom_range(0, 3))
      0: send_number($urandom_range(int'(NOTE_LIMIT), int'(DIGIT_SAT)));
      1: send_number($urandom_range(0, 19) * OctaveStep + $urandom_range(KeysPerOctave, 99));
      2: repeat ($urandom_range(4, 7)) send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
      default: begin
        if ($urandom_range(0, 1) == 0) send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        send_char(pick_filler());
      end
    endcase
  endtask

  // One beat line. A tidy line has its bracket and only valid notes; an
  // untidy one may lose the bracket and carry rejected notes.
  task automatic send_line(input bit tidy);
    int unsigned count;
    repeat ($urandom_range(0, 2)) send_char(pick_filler());
    if (tidy || $urandom_range(0, 3) != 0) send_char(CH_CLOSE);
    count = $urandom_range(0, 4);
    for (int i = 0; i < count; i++) begin
      if (i > 0) send_char(CH_BAR);
      if (tidy || $urandom_range(0, 2) != 0) send_number(pick_note());
      else send_bad_token();
    end
    if ($urandom_range(0, 4) == 0) send_char(CH_BAR);
    if ($urandom_range(0, 9) == 0) send_eof();
    else send_char(CH_NEWLINE);
  endtask

  // Raw noise: any byte values, closed by a newline.
  task automatic send_noise();
    repeat ($urandom_range(1, 12)) send_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
    send_item(CH_NEWLINE, 1'b0);
  endtask

  initial begin
    int unsigned shape;
    bit          first_hold, second_hold;
    sb = new(NotesPerBeat);
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.char_code = '0;
    in_if.end_of_input = 1'b0;
    sent_bytes = 0;
    burst_left = 0;
    cycles = 0;
    hold_req = 1'b0;
    first_hold = 1'b0;
    second_hold = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed lines. The first has junk before the bracket, note zero, the
    // largest valid note and a short note, and ends on a number. Then come
    // a bare newline (error raised on the newline itself), a bar before any
    // bracket, a bad character after a note, a saturating digit string, a
    // note whose key is out of range ending on the newline, a letter inside
    // a number closed by end of file, a note closed by end of file, end of
    // file with nothing pending, and a line that fills the beat to its
    // capacity and then carries one note too many.
    send_text("a]0|1911|1000\n");
    send_text("\n");
    send_text("x|9\n");
    send_text("] 1 1|x9\n");
    send_text("]99999|2000|\n");
    send_text("]12\n");
    send_text("]5a");
    send_eof();
    send_text("]3");
    send_eof();
    send_eof();
    send_char(CH_CLOSE);
    for (int i = 0; i <= NotesPerBeat; i++) begin
      if (i > 0) send_char(CH_BAR);
      send_number(pick_note());
    end
    send_char(CH_NEWLINE);
    // Extreme byte values, and an end-of-file mark whose byte is all ones.
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);

    // Random part: mostly well-formed lines with random content, the rest
    // damaged lines and raw noise. Twice the receiver holds off for a long
    // stretch while the sender keeps offering bytes.
    while (sent_bytes < RandomBytes) begin
      if (!first_hold && sent_bytes > 400) begin
        hold_req = 1'b1;
        first_hold = 1'b1;
      end
      if (!second_hold && sent_bytes > 1300) begin
        hold_req = 1'b1;
        second_hold = 1'b1;
      end
      shape = $urandom_range(0, 99);
      if (shape < 65) send_line(1'b1);
      else if (shape < 88) send_line(1'b0);
      else send_noise();
    end

    @(negedge clk);
    in_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
